[design/cmm_pkg.sv]
`timescale 1ns / 1ps

package cmm_pkg;

   // Class id field width and ratio field width (Q1.16) on the result channel.
   localparam int CLASS_W = 4;
   localparam int RATIO_W = 17;

   // Item kinds on the result channel.
   localparam logic KIND_CLASS    = 1'b0;
   localparam logic KIND_ACCURACY = 1'b1;

   // Request modes.
   localparam logic MODE_ACCUMULATE = 1'b0;
   localparam logic MODE_REPORT     = 1'b1;

endpackage

[design/cmm_if.sv]
`timescale 1ns / 1ps

interface cmm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [cmm_pkg::CLASS_W-1:0] true_class;
   logic [cmm_pkg::CLASS_W-1:0] predicted_class;

   modport source (output valid, mode, true_class, predicted_class, input ready);
   modport sink   (input valid, mode, true_class, predicted_class, output ready);
endinterface

interface cmm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [cmm_pkg::CLASS_W-1:0] class_id;
   logic [cmm_pkg::RATIO_W-1:0] precision;
   logic [cmm_pkg::RATIO_W-1:0] recall;
   logic [cmm_pkg::RATIO_W-1:0] f1;
   logic [cmm_pkg::RATIO_W-1:0] accuracy;
   logic                        empty_res;
   logic                        last;

   modport source (output valid, kind, class_id, precision, recall, f1, accuracy,
                   empty_res, last, input ready);
   modport sink   (input valid, kind, class_id, precision, recall, f1, accuracy,
                   empty_res, last, output ready);
endinterface

[design/cmm_div.sv]
`timescale 1ns / 1ps

// Restoring divider giving floor(num * 2^FRAC_BITS / den) for num <= den,
// one quotient bit per cycle. A zero denominator yields zero.
module cmm_div #(
   parameter int WIDTH     = 40,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     num,
   input  logic [WIDTH-1:0]     den,
   output logic                 done,
   output logic [FRAC_BITS:0]   quot
);

   localparam int STEPS = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [WIDTH:0]     rem_ff, rem_in;
   logic [WIDTH-1:0]   den_ff;
   logic [FRAC_BITS:0] quot_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [WIDTH:0]     trial;
   logic               fits;

   // The integer bit is taken without a shift; every fraction bit shifts first.
   assign trial  = (cnt_ff == CNT_W'(STEPS)) ? rem_ff : {rem_ff[WIDTH-1:0], 1'b0};
   assign fits   = trial >= {1'b0, den_ff};
   assign rem_in = fits ? (trial - {1'b0, den_ff}) : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, num};
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[FRAC_BITS-1:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = (den_ff == '0) ? '0 : quot_ff;

endmodule

[design/confusion_matrix_metrics.sv]
`timescale 1ns / 1ps

// Confusion-matrix metrics. Accumulate beats are taken one per cycle while the
// block is idle: each is a read-modify-write of one saturating counter in the
// pair-count memory, with the previous write forwarded when two beats hit the
// same pair. A report beat walks every seen class below 16: it reads the row and
// column of the class through the two memory read ports and sums them, runs the
// three serial dividers, then sends the result beat; the accuracy beat comes
// last. After reset and after every report a clearing pass over all
// 2^(2*clog2(NUM_CLASSES)) entries zeroes the memory, during which no request
// beat is accepted.
module confusion_matrix_metrics #(
   parameter int NUM_CLASSES = 16,
   parameter int COUNT_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic      clock,
   input  logic      reset,
   cmm_req_if.sink   req_chan,
   cmm_rsp_if.source rsp_chan
);

   localparam int CW       = $clog2(NUM_CLASSES);
   localparam int AW       = 2 * CW;
   localparam int DEPTH    = 1 << AW;
   localparam int SW       = COUNT_WIDTH + CW;
   localparam int DW       = SW + 1;
   localparam int ID_LIMIT = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_SCAN    = 11'b000_0000_0010,
      ST_READ    = 11'b000_0000_0100,
      ST_DRAIN   = 11'b000_0000_1000,
      ST_DIVGO   = 11'b000_0001_0000,
      ST_DIVWAIT = 11'b000_0010_0000,
      ST_SEND    = 11'b000_0100_0000,
      ST_ACCGO   = 11'b000_1000_0000,
      ST_ACCWAIT = 11'b001_0000_0000,
      ST_ACCSEND = 11'b010_0000_0000,
      ST_CLEAR   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] mem_ff [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]          addr_a, addr_b;

   logic [NUM_CLASSES-1:0] seen_ff;
   logic [COUNT_WIDTH-1:0] sample_ff, correct_ff;

   logic                   acc_vld_ff;
   logic [AW-1:0]          acc_addr_ff;
   logic                   lw_vld_ff;
   logic [AW-1:0]          lw_addr_ff;
   logic [COUNT_WIDTH-1:0] lw_data_ff;
   logic [COUNT_WIDTH-1:0] acc_old, acc_new;

   logic [CW-1:0]          cls_ff, cls_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   rd_vld_ff;
   logic [CW-1:0]          rd_idx_ff;
   logic [SW-1:0]          row_sum_ff, col_sum_ff;
   logic [COUNT_WIDTH-1:0] tp_ff;
   logic [AW-1:0]          clr_ff, clr_in;

   logic                   req_accept, in_range;
   logic [CW-1:0]          tc_idx, pc_idx;
   logic                   cls_last, idx_last, seen_cur;

   logic                   div_start;
   logic [DW-1:0]          num_p, den_p, num_r, den_r, num_f, den_f;
   logic                   div_done;
   logic [FRAC_BITS:0]     q_p, q_r, q_f;

   logic                              rsp_valid_ff;
   logic                              rsp_kind_ff, rsp_empty_ff;
   logic [cmm_pkg::CLASS_W-1:0]       rsp_class_ff;
   logic [cmm_pkg::RATIO_W-1:0]       rsp_prec_ff, rsp_rec_ff, rsp_f1_ff, rsp_acc_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign tc_idx         = CW'(req_chan.true_class);
   assign pc_idx         = CW'(req_chan.predicted_class);
   assign in_range = ({3'b000, req_chan.true_class} < 7'(NUM_CLASSES)) &&
                     ({3'b000, req_chan.predicted_class} < 7'(NUM_CLASSES));

   assign cls_last = (cls_ff == CW'(ID_LIMIT - 1));
   assign idx_last = (idx_ff == CW'(NUM_CLASSES - 1));
   assign seen_cur = seen_ff[cls_ff];

   // Port A serves accumulate beats and row reads; port B reads the column.
   assign addr_a = (state_ff == ST_IDLE) ? {tc_idx, pc_idx} : {cls_ff, idx_ff};
   assign addr_b = {idx_ff, cls_ff};

   // A beat on the same pair as the one written last cycle sees stale read data.
   assign acc_old = (lw_vld_ff && lw_addr_ff == acc_addr_ff) ? lw_data_ff : rd_a_ff;
   assign acc_new = (&acc_old) ? acc_old : acc_old + 1'b1;

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[addr_a];
      rd_b_ff <= mem_ff[addr_b];
      if (acc_vld_ff) begin
         mem_ff[acc_addr_ff] <= acc_new;
      end else if (state_ff == ST_CLEAR) begin
         mem_ff[clr_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      lw_addr_ff  <= acc_addr_ff;
      lw_data_ff  <= acc_new;
      acc_addr_ff <= {tc_idx, pc_idx};
      rd_idx_ff   <= idx_ff;
   end

   always_comb begin
      state_in = state_ff;
      cls_in   = cls_ff;
      idx_in   = idx_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_chan.mode == cmm_pkg::MODE_REPORT) begin
               cls_in   = '0;
               state_in = (sample_ff == '0) ? ST_ACCGO : ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = '0;
            if (seen_cur) begin
               state_in = ST_READ;
            end else if (cls_last) begin
               state_in = ST_ACCGO;
            end else begin
               cls_in = cls_ff + 1'b1;
            end
         end
         ST_READ: begin
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:   state_in = ST_DIVGO;
         ST_DIVGO:   state_in = ST_DIVWAIT;
         ST_DIVWAIT: begin
            if (div_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_chan.ready) begin
               if (cls_last) begin
                  state_in = ST_ACCGO;
               end else begin
                  cls_in   = cls_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ACCGO:   state_in = ST_ACCWAIT;
         ST_ACCWAIT: begin
            if (div_done) begin
               state_in = ST_ACCSEND;
            end
         end
         ST_ACCSEND: begin
            if (rsp_chan.ready) begin
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         acc_vld_ff <= 1'b0;
         lw_vld_ff  <= 1'b0;
         rd_vld_ff  <= 1'b0;
         seen_ff    <= '0;
         sample_ff  <= '0;
         correct_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         lw_vld_ff  <= acc_vld_ff;
         rd_vld_ff  <= (state_ff == ST_READ);
         acc_vld_ff <= req_accept && req_chan.mode == cmm_pkg::MODE_ACCUMULATE &&
                       in_range;
         if (req_accept && req_chan.mode == cmm_pkg::MODE_ACCUMULATE && in_range) begin
            seen_ff[tc_idx] <= 1'b1;
            seen_ff[pc_idx] <= 1'b1;
            if (!(&sample_ff)) begin
               sample_ff <= sample_ff + 1'b1;
            end
            if (tc_idx == pc_idx && !(&correct_ff)) begin
               correct_ff <= correct_ff + 1'b1;
            end
         end
         if (state_ff == ST_ACCSEND && rsp_chan.ready) begin
            seen_ff    <= '0;
            sample_ff  <= '0;
            correct_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff <= cls_in;
      idx_ff <= idx_in;
      if (state_ff == ST_SCAN) begin
         row_sum_ff <= '0;
         col_sum_ff <= '0;
      end else if (rd_vld_ff) begin
         row_sum_ff <= row_sum_ff + SW'(rd_a_ff);
         col_sum_ff <= col_sum_ff + SW'(rd_b_ff);
         if (rd_idx_ff == cls_ff) begin
            tp_ff <= rd_a_ff;
         end
      end
   end

   // The precision divider u_div_p is shared with the accuracy ratio.
   assign div_start = (state_ff == ST_DIVGO) || (state_ff == ST_ACCGO);
   assign num_p = (state_ff == ST_ACCGO) ? DW'(correct_ff) : DW'(tp_ff);
   assign den_p = (state_ff == ST_ACCGO) ? DW'(sample_ff) : DW'(col_sum_ff);
   assign num_r = DW'(tp_ff);
   assign den_r = DW'(row_sum_ff);
   assign num_f = {DW'(tp_ff)} << 1;
   assign den_f = DW'(row_sum_ff) + DW'(col_sum_ff);

   cmm_div #(.WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_p (
      .clock(clock), .reset(reset), .start(div_start), .num(num_p), .den(den_p),
      .done(div_done), .quot(q_p)
   );

   cmm_div #(.WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_r (
      .clock(clock), .reset(reset), .start(div_start), .num(num_r), .den(den_r),
      .done(), .quot(q_r)
   );

   cmm_div #(.WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_f (
      .clock(clock), .reset(reset), .start(div_start), .num(num_f), .den(den_f),
      .done(), .quot(q_f)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done && state_ff == ST_DIVWAIT) begin
         rsp_kind_ff  <= cmm_pkg::KIND_CLASS;
         rsp_class_ff <= cmm_pkg::CLASS_W'(cls_ff);
         rsp_prec_ff  <= cmm_pkg::RATIO_W'(q_p);
         rsp_rec_ff   <= cmm_pkg::RATIO_W'(q_r);
         rsp_f1_ff    <= cmm_pkg::RATIO_W'(q_f);
         rsp_acc_ff   <= '0;
         rsp_empty_ff <= 1'b0;
      end else if (div_done) begin
         rsp_kind_ff  <= cmm_pkg::KIND_ACCURACY;
         rsp_class_ff <= '0;
         rsp_prec_ff  <= '0;
         rsp_rec_ff   <= '0;
         rsp_f1_ff    <= '0;
         rsp_acc_ff   <= cmm_pkg::RATIO_W'(q_p);
         rsp_empty_ff <= (sample_ff == '0);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_kind_ff;
   assign rsp_chan.class_id  = rsp_class_ff;
   assign rsp_chan.precision = rsp_prec_ff;
   assign rsp_chan.recall    = rsp_rec_ff;
   assign rsp_chan.f1        = rsp_f1_ff;
   assign rsp_chan.accuracy  = rsp_acc_ff;
   assign rsp_chan.empty_res = rsp_empty_ff;
   assign rsp_chan.last      = (rsp_kind_ff == cmm_pkg::KIND_ACCURACY);

endmodule
